@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define AFRR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define AFRR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, always on
`define AFRR_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/afrr_pkg.sv @@
// ----------------------------------------------------------------------------
// afrr_pkg
// Types, constants and helpers of the addressed frame receiver responder.
// ----------------------------------------------------------------------------
package afrr_pkg;

   localparam int SAMPLE_DEPTH = 8;
   localparam int SLOT_W       = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SAMPLE_DEPTH - 1);

   localparam int JOB_DEPTH  = 2;
   localparam int JOB_PTR_W  = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
   localparam int JOB_CNT_W  = $clog2(JOB_DEPTH + 1);
   localparam logic [JOB_PTR_W-1:0] JOB_PTR_LAST = JOB_PTR_W'(JOB_DEPTH - 1);
   localparam logic [JOB_CNT_W-1:0] JOB_CNT_FULL = JOB_CNT_W'(JOB_DEPTH);

   localparam logic [7:0] BYTE_START_CMD = 8'd244;
   localparam logic [7:0] BYTE_START_ID  = 8'd254;
   localparam logic [7:0] BYTE_REPLY     = 8'd240;
   localparam logic [7:0] ACT_REPLY      = 8'd100;
   localparam logic [7:0] ACT_COMMIT     = 8'd110;
   localparam logic [7:0] ID_LOW         = 8'd10;
   localparam logic [7:0] ID_HIGH        = 8'd41;
   localparam logic [7:0] NODE_ID_RESET  = 8'd11;

   localparam logic       OP_BUS_BYTE = 1'b0;

   localparam logic [1:0] BEAT_FIRST = 2'd0;
   localparam logic [1:0] BEAT_ID    = 2'd1;
   localparam logic [1:0] BEAT_STAT  = 2'd2;
   localparam logic [1:0] BEAT_LAST  = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CMD_ID,
      PH_CMD_CMD,
      PH_CMD_CHK,
      PH_SET_ID,
      PH_SET_NEW,
      PH_SET_CHK,
      PH_SET_ACT
   } phase_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
      logic [3:0] sensor_nibble;
      logic [2:0] line_status;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_last;
      logic [7:0] relay_command;
   } rsp_type;

   typedef struct packed {
      logic [7:0] node_id;
      logic [6:0] status;
      logic [7:0] relay_command;
   } job_type;

   function automatic rsp_type reply_beat(job_type job, logic [1:0] beat);
      rsp_type    r;
      logic [6:0] chk;
      chk             = job.status + job.node_id[6:0];
      r.relay_command = job.relay_command;
      r.frame_last    = (beat == BEAT_LAST);
      case (beat)
         BEAT_FIRST: r.tx_byte = BYTE_REPLY;
         BEAT_ID:    r.tx_byte = job.node_id;
         BEAT_STAT:  r.tx_byte = {1'b0, job.status};
         BEAT_LAST:  r.tx_byte = {1'b0, chk};
         default:    r.tx_byte = BYTE_REPLY;
      endcase
      return r;
   endfunction

endpackage

@@ src/afrr_frame_parser.sv @@
// ----------------------------------------------------------------------------
// afrr_frame_parser
// Accepts bus bytes and sensor samples, runs the frame parser and queues
// reply jobs.
// ----------------------------------------------------------------------------
module afrr_frame_parser import afrr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    job_valid,
   input  logic    job_ready,
   output job_type job_data
);

   phase_type         phase_ff, phase_in;
   logic [7:0]        node_id_ff, node_id_in;
   logic [7:0]        proposed_ff, proposed_in;
   logic [7:0]        command_ff, command_in;
   logic [3:0]        ring_ff [SAMPLE_DEPTH];
   logic [SLOT_W-1:0] slot_ff, slot_in;

   logic       accept;
   logic       bus_byte;
   logic [7:0] b;
   logic [3:0] ring_and;
   logic       cmd_match;
   logic       id_match;
   logic       id_in_range;

   assign req_ready = job_ready;
   assign accept    = req_valid && req_ready;
   assign bus_byte  = accept && (req_data.opcode == OP_BUS_BYTE);
   assign b         = req_data.rx_byte;

   assign cmd_match   = ({1'b0, b} == ({1'b0, command_ff} + {1'b0, node_id_ff}));
   assign id_match    = ({1'b0, b} == ({1'b0, proposed_ff} + {1'b0, node_id_ff}));
   assign id_in_range = (b >= ID_LOW) && (b <= ID_HIGH);

   always_comb begin
      ring_and = 4'hF;
      for (int i = 0; i < SAMPLE_DEPTH; i++) begin
         ring_and = ring_and & ring_ff[i];
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (bus_byte) begin
         phase_in = PH_IDLE;
         case (phase_ff)
            PH_IDLE: begin
               if (b == BYTE_START_CMD) phase_in = PH_CMD_ID;
               else if (b == BYTE_START_ID) phase_in = PH_SET_ID;
            end
            PH_CMD_ID:  if (b == node_id_ff) phase_in = PH_CMD_CMD;
            PH_CMD_CMD: phase_in = PH_CMD_CHK;
            PH_SET_ID:  if (b == node_id_ff) phase_in = PH_SET_NEW;
            PH_SET_NEW: if (id_in_range) phase_in = PH_SET_CHK;
            PH_SET_CHK: if (id_match) phase_in = PH_SET_ACT;
            default:    phase_in = PH_IDLE;
         endcase
      end
   end

   // outputs and data updates
   always_comb begin
      node_id_in  = node_id_ff;
      proposed_in = proposed_ff;
      command_in  = command_ff;
      job_valid   = 1'b0;
      job_data.node_id       = node_id_ff;
      job_data.status        = {req_data.line_status, ring_and};
      job_data.relay_command = command_ff;
      if (bus_byte) begin
         case (phase_ff)
            PH_CMD_CMD: command_in = b;
            PH_CMD_CHK: job_valid = cmd_match;
            PH_SET_NEW: if (id_in_range) proposed_in = b;
            PH_SET_ACT: begin
               if (b == ACT_REPLY) job_valid = 1'b1;
               else if (b == ACT_COMMIT) node_id_in = proposed_ff;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      slot_in = slot_ff;
      if (accept && (req_data.opcode != OP_BUS_BYTE)) begin
         slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         node_id_ff  <= NODE_ID_RESET;
         proposed_ff <= '0;
         command_ff  <= '0;
         slot_ff     <= '0;
         for (int i = 0; i < SAMPLE_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         phase_ff    <= phase_in;
         node_id_ff  <= node_id_in;
         proposed_ff <= proposed_in;
         command_ff  <= command_in;
         slot_ff     <= slot_in;
         if (accept && (req_data.opcode != OP_BUS_BYTE)) begin
            ring_ff[slot_ff] <= req_data.sensor_nibble;
         end
      end
   end

endmodule

@@ src/afrr_job_queue.sv @@
// ----------------------------------------------------------------------------
// afrr_job_queue
// Short first-in first-out queue of reply jobs between parser and transmitter.
// ----------------------------------------------------------------------------
module afrr_job_queue import afrr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_data
);

   job_type              entry_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_W-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign push_ready = (count_ff != JOB_CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == JOB_PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == JOB_PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/afrr_reply_tx.sv @@
// ----------------------------------------------------------------------------
// afrr_reply_tx
// Pops reply jobs and sends each as four bytes through an output register.
// ----------------------------------------------------------------------------
module afrr_reply_tx import afrr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   output logic    job_ready,
   input  job_type job_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       busy_ff, busy_in;
   logic [1:0] beat_ff, beat_in;
   job_type    job_ff, job_in;
   logic       load;

   assign load      = !rsp_valid_ff || rsp_ready;
   assign job_ready = load && !busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      busy_in      = busy_ff;
      beat_in      = beat_ff;
      job_in       = job_ff;
      if (load) begin
         if (busy_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = reply_beat(job_ff, beat_ff);
            beat_in      = beat_ff + 1'b1;
            busy_in      = (beat_ff != BEAT_LAST);
         end else if (job_valid) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = reply_beat(job_data, BEAT_FIRST);
            job_in       = job_data;
            beat_in      = BEAT_ID;
            busy_in      = 1'b1;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
         beat_ff      <= BEAT_FIRST;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         busy_ff      <= busy_in;
         beat_ff      <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      job_ff      <= job_in;
   end

endmodule

@@ src/addressed_frame_receiver_responder_unit.sv @@
// ----------------------------------------------------------------------------
// addressed_frame_receiver_responder_unit
// Slave side of a byte-framed station bus: frame parser, reply queue and
// reply transmitter.
//
//   channel  | direction | payload  | accepted when
//   req_     | in        | req_type | req_valid && req_ready
//   rsp_     | out       | rsp_type | rsp_valid && rsp_ready
//
// One input item is taken per cycle while the reply queue has room.
// A reply leaves as four bytes from the output register while rsp_ready is high;
// the transmitter takes no new job until the last byte of a reply is loaded.
// The first reply byte reaches rsp_ via the queue entry and the output register.
// Synchronous active-high reset; the sample ring clears at once.
// A stalled rsp_ channel fills the queue, then req_ready drops.
// ----------------------------------------------------------------------------
module addressed_frame_receiver_responder_unit import afrr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    push_valid;
   logic    push_ready;
   job_type push_data;
   logic    pop_valid;
   logic    pop_ready;
   job_type pop_data;

   afrr_frame_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (push_valid),
      .job_ready (push_ready),
      .job_data  (push_data)
   );

   afrr_job_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   afrr_reply_tx u_tx (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ src/afrr_checker.sv @@
// ----------------------------------------------------------------------------
// afrr_checker
// Port-level assertions for the addressed frame receiver responder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module afrr_checker import afrr_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `AFRR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp item changed while stalled")
   `AFRR_ASSERT_IMPL(a_last_check, clock, reset, rsp_valid && rsp_data.frame_last, rsp_data.tx_byte[7] == 1'b0, "reply check byte above 127")
   `AFRR_ASSERT_NEXT_ALWAYS(a_reset_rsp, clock, reset, !rsp_valid, "rsp_valid high after reset")
   `AFRR_ASSERT_NEXT_ALWAYS(a_reset_req, clock, reset, req_ready, "req_ready low after reset")

endmodule

bind addressed_frame_receiver_responder_unit afrr_checker u_checker (.*);

@@ test/addressed_frame_receiver_responder_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressed_frame_receiver_responder_unit_test
// Self-checking bench for the station bus responder. A behavioral model of
// the frame parser and sample ring predicts every reply byte from the
// accepted input items; a scoreboard process compares each accepted reply
// byte with the oldest prediction. Directed frames come first, then random
// well-formed frames mixed with samples, noise and broken frames, with
// random idling on both channels, a long output stall and a drain pause.
// ----------------------------------------------------------------------------
module addressed_frame_receiver_responder_unit_test;
   import afrr_pkg::*;

   localparam int RESET_CYCLES   = 10;
   localparam int LONG_STALL     = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 360;
   localparam int SETTLE_CYCLES  = 16;
   localparam int MAX_REPORTS    = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // station model
   phase_type         parse_phase = PH_IDLE;
   logic [7:0]        node_id = NODE_ID_RESET;
   logic [7:0]        proposed_id = '0;
   logic [7:0]        latched_command = '0;
   logic [3:0]        ring_nibbles [SAMPLE_DEPTH];
   logic [SLOT_W-1:0] ring_slot = '0;

   rsp_type reply_bytes_due [$];

   int  items_sent = 0;
   int  frames_sent = 0;
   int  replies_predicted = 0;
   int  reply_bytes_seen = 0;
   int  mismatches = 0;
   int  idle_cycles = 0;
   int  stall_left = 0;
   int  run_left = 0;
   bit  long_stall_asked = 1'b0;
   bit  steady = 1'b0;

   addressed_frame_receiver_responder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 70) begin
         return $urandom_range(2, 1);
      end else if (r < 95) begin
         return $urandom_range(8, 3);
      end
      return $urandom_range(60, 20);
   endfunction

   task automatic queue_reply(input logic [2:0] line);
      logic [3:0] low;
      logic [6:0] status;
      logic [7:0] total;
      rsp_type    beat;
      low = 4'hF;
      foreach (ring_nibbles[i]) low &= ring_nibbles[i];
      status = {line, low};
      total  = {1'b0, status} + node_id;
      beat.relay_command = latched_command;
      beat.frame_last    = 1'b0;
      beat.tx_byte       = BYTE_REPLY;
      reply_bytes_due.push_back(beat);
      beat.tx_byte = node_id;
      reply_bytes_due.push_back(beat);
      beat.tx_byte = {1'b0, status};
      reply_bytes_due.push_back(beat);
      beat.tx_byte    = {1'b0, total[6:0]};
      beat.frame_last = 1'b1;
      reply_bytes_due.push_back(beat);
      replies_predicted++;
   endtask

   task automatic step_station(input req_type it);
      logic [8:0] sum;
      logic [7:0] b;
      phase_type  was;
      if (it.opcode != OP_BUS_BYTE) begin
         ring_nibbles[ring_slot] = it.sensor_nibble;
         ring_slot = (ring_slot == SLOT_LAST) ? '0 : ring_slot + 1'b1;
         return;
      end
      b = it.rx_byte;
      was = parse_phase;
      parse_phase = PH_IDLE;
      case (was)
         PH_IDLE: begin
            if (b == BYTE_START_CMD) parse_phase = PH_CMD_ID;
            else if (b == BYTE_START_ID) parse_phase = PH_SET_ID;
         end
         PH_CMD_ID: begin
            if (b == node_id) parse_phase = PH_CMD_CMD;
         end
         PH_CMD_CMD: begin
            latched_command = b;
            parse_phase = PH_CMD_CHK;
         end
         PH_CMD_CHK: begin
            sum = {1'b0, latched_command} + {1'b0, node_id};
            if ({1'b0, b} == sum) queue_reply(it.line_status);
         end
         PH_SET_ID: begin
            if (b == node_id) parse_phase = PH_SET_NEW;
         end
         PH_SET_NEW: begin
            if (b >= ID_LOW && b <= ID_HIGH) begin
               proposed_id = b;
               parse_phase = PH_SET_CHK;
            end
         end
         PH_SET_CHK: begin
            sum = {1'b0, proposed_id} + {1'b0, node_id};
            if ({1'b0, b} == sum) parse_phase = PH_SET_ACT;
         end
         default: begin
            if (b == ACT_REPLY) queue_reply(it.line_status);
            else if (b == ACT_COMMIT) node_id = proposed_id;
         end
      endcase
   endtask

   // hold valid across back-to-back items, drop it only for a gap
   task automatic offer_item(input req_type it);
      int gap;
      gap = (steady || $urandom_range(1) == 0) ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      step_station(it);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      req_type it;
      it.opcode        = OP_BUS_BYTE;
      it.rx_byte       = b;
      it.sensor_nibble = 4'($urandom_range(15));
      it.line_status   = 3'($urandom_range(7));
      offer_item(it);
   endtask

   task automatic send_nibble(input logic [3:0] n);
      req_type it;
      it.opcode        = ~OP_BUS_BYTE;
      it.rx_byte       = 8'($urandom_range(255));
      it.sensor_nibble = n;
      it.line_status   = 3'($urandom_range(7));
      offer_item(it);
   endtask

   task automatic send_command_frame(input logic [7:0] cmd, input bit good);
      logic [8:0] sum;
      sum = {1'b0, cmd} + {1'b0, node_id};
      send_byte(BYTE_START_CMD);
      send_byte(node_id);
      send_byte(cmd);
      send_byte(good ? sum[7:0] : 8'($urandom_range(255)));
      frames_sent++;
   endtask

   task automatic send_id_frame(input logic [7:0] newid, input bit good,
                                input logic [7:0] action);
      logic [8:0] sum;
      sum = {1'b0, newid} + {1'b0, node_id};
      send_byte(BYTE_START_ID);
      send_byte(node_id);
      send_byte(newid);
      send_byte(good ? sum[7:0] : 8'($urandom_range(255)));
      send_byte(action);
      frames_sent++;
   endtask

   task automatic flush_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (reply_bytes_due.size() != 0);
   endtask

   task automatic check_reply_byte(input rsp_type got);
      rsp_type want;
      reply_bytes_seen++;
      if (reply_bytes_due.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("unexpected reply byte: tx %0d last %0d relay %0d",
                     got.tx_byte, got.frame_last, got.relay_command);
         return;
      end
      want = reply_bytes_due.pop_front();
      if (got.tx_byte !== want.tx_byte || got.frame_last !== want.frame_last ||
          got.relay_command !== want.relay_command) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("mismatch: want tx %0d last %0d relay %0d, got tx %0d last %0d relay %0d",
                     want.tx_byte, want.frame_last, want.relay_command,
                     got.tx_byte, got.frame_last, got.relay_command);
      end
   endtask

   // output side: check accepted bytes, then pick ready for the next cycle
   initial begin : reply_side
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) check_reply_byte(rsp_data);
         if (long_stall_asked) begin
            long_stall_asked = 1'b0;
            stall_left = LONG_STALL;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (steady) begin
            rsp_ready <= 1'b1;
         end else if (run_left > 0) begin
            run_left--;
            rsp_ready <= 1'b1;
         end else begin
            run_left = $urandom_range(40);
            stall_left = pick_gap() - 1;
            rsp_ready <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", idle_cycles);
         $display("addressed_frame_receiver_responder_unit_test: errors");
         $finish;
      end
   end

   task automatic test_idle_noise();
      send_byte(8'd0);
      send_byte(8'd255);
      send_byte(BYTE_REPLY);
      send_byte(ACT_REPLY);
      flush_replies();
   endtask

   task automatic test_command_frames();
      // saturate the ring so the status nibble reads all ones
      repeat (SAMPLE_DEPTH) send_nibble(4'hF);
      send_command_frame(8'd0, 1'b1);
      send_command_frame(8'd244, 1'b1);
      send_command_frame(8'd250, 1'b0);
      send_byte(BYTE_START_CMD);
      send_byte(node_id + 8'd1);
      // samples inside a frame leave the parser alone
      send_byte(BYTE_START_CMD);
      send_nibble(4'h7);
      send_byte(node_id);
      send_byte(8'd3);
      send_nibble(4'hF);
      send_byte(8'd3 + node_id);
      flush_replies();
   endtask

   task automatic test_id_frames();
      send_id_frame(ID_HIGH, 1'b1, ACT_REPLY);
      send_id_frame(ID_LOW, 1'b1, ACT_COMMIT);
      send_id_frame(8'd20, 1'b1, 8'd7);
      send_byte(BYTE_START_ID);
      send_byte(node_id);
      send_byte(ID_LOW - 8'd1);
      send_byte(BYTE_START_ID);
      send_byte(node_id);
      send_byte(ID_HIGH + 8'd1);
      send_command_frame(8'd255, 1'b1);
      flush_replies();
   endtask

   task automatic test_output_stall();
      long_stall_asked = 1'b1;
      repeat (12) send_command_frame(8'($urandom_range(255)), 1'b1);
      flush_replies();
   endtask

   task automatic test_back_to_back();
      steady = 1'b1;
      repeat (8) send_id_frame(8'($urandom_range(41, 10)), 1'b1, ACT_REPLY);
      flush_replies();
      steady = 1'b0;
   endtask

   task automatic test_random_traffic();
      int start;
      int r;
      logic [7:0] newid;
      logic [7:0] action;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         r = $urandom_range(99);
         if (r < 40) begin
            send_command_frame(8'($urandom_range(255)), $urandom_range(99) < 85);
         end else if (r < 65) begin
            newid = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                             : 8'($urandom_range(41, 10));
            r = $urandom_range(99);
            action = (r < 50) ? ACT_REPLY : (r < 70) ? ACT_COMMIT
                                                     : 8'($urandom_range(255));
            send_id_frame(newid, $urandom_range(99) < 85, action);
         end else if (r < 85) begin
            send_nibble(($urandom_range(99) < 70) ? 4'hF : 4'($urandom_range(15)));
         end else if (r < 93) begin
            send_byte(8'($urandom_range(255)));
         end else begin
            send_byte(($urandom_range(1) == 0) ? BYTE_START_CMD : BYTE_START_ID);
            if ($urandom_range(1) == 0) send_byte(node_id);
            send_byte(8'($urandom_range(255)));
         end
         if ($urandom_range(40) == 0) flush_replies();
      end
      flush_replies();
   endtask

   initial begin
      foreach (ring_nibbles[i]) ring_nibbles[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_noise();
      test_command_frames();
      test_id_frames();
      test_output_stall();
      test_back_to_back();
      test_random_traffic();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d items in %0d frames, %0d replies predicted, %0d reply bytes checked",
               items_sent, frames_sent, replies_predicted, reply_bytes_seen);
      $display("included a long output stall, back-to-back traffic and drain pauses");
      if (mismatches == 0 && reply_bytes_due.size() == 0) begin
         $display("addressed_frame_receiver_responder_unit_test: clean");
      end else begin
         $display("%0d mismatches, %0d reply bytes never arrived",
                  mismatches, reply_bytes_due.size());
         $display("addressed_frame_receiver_responder_unit_test: errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/afrr_pkg.sv
src/afrr_frame_parser.sv
src/afrr_job_queue.sv
src/afrr_reply_tx.sv
src/addressed_frame_receiver_responder_unit.sv
src/afrr_checker.sv
test/addressed_frame_receiver_responder_unit_test.sv
